### sv/mrpt_pkg.sv
`default_nettype none

package mrpt_pkg;

    // Candidate port width and default tested width
    localparam int CAND_WIDTH    = 32;
    localparam int NUM_WIDTH_DEF = 32;

    // Witness bases and small-case bounds
    localparam int WITNESS_COUNT     = 3;
    localparam int IDX_W             = $clog2(WITNESS_COUNT);
    localparam int SMALL_PRIME_LIMIT = 9;

    // Map a witness index to its base
    function automatic logic [7:0] witness_base(input logic [IDX_W-1:0] idx);
        logic [7:0] base;
        case (idx)
            2'd0:    base = 8'd2;
            2'd1:    base = 8'd7;
            2'd2:    base = 8'd61;
            default: base = 8'd2;
        endcase
        return base;
    endfunction

    // Fold one more bit into a running remainder modulo 3, MSB first
    function automatic logic [1:0] mod3_step(input logic [1:0] rem, input logic bit_in);
        logic [1:0] res;
        case ({rem, bit_in})
            3'd0:    res = 2'd0;
            3'd1:    res = 2'd1;
            3'd2:    res = 2'd2;
            3'd3:    res = 2'd0;
            3'd4:    res = 2'd1;
            3'd5:    res = 2'd2;
            default: res = 2'd0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

### sv/miller_rabin_prime_test_32_unit.sv
`default_nettype none

// Deterministic Miller-Rabin primality test. Pulse start while busy is low to
// launch a request on candidate; only its low NUM_WIDTH bits are tested. The
// answer appears on prime_flag for exactly one cycle with done high, and busy
// drops in that same cycle. The receiver cannot stall, so sample prime_flag
// whenever done is high. Trivial candidates (below 9, even) are answered in
// ST_CLASSIFY; others first run a bit-serial test for divisibility by 3,
// then run bases 2, 7 and 61 on one shared shift-add modular multiplier
// that retires each multiplier bit as a double step followed by an add
// step. A base needs up to about 2*NUM_WIDTH multiplications; a composite
// that fails its first base finishes sooner.
module miller_rabin_prime_test_32_unit #(
    parameter int NUM_WIDTH = mrpt_pkg::NUM_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [mrpt_pkg::CAND_WIDTH-1:0] candidate,
    output logic                                 done,
    output logic                                 prime_flag
);
    import mrpt_pkg::*;

    localparam int W  = NUM_WIDTH;
    localparam int CW = $clog2(W);
    localparam logic [CW-1:0]    CNT_MAX  = CW'(W - 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WITNESS_COUNT - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_MOD3,
        ST_SPLIT,
        ST_BASE,
        ST_EXP,
        ST_MUL,
        ST_CHECK,
        ST_LOOP,
        ST_LOOP_CHK
    } state_t;

    typedef enum logic [1:0] {
        TGT_ACC_EXP,
        TGT_SQ,
        TGT_ACC_LOOP
    } tgt_t;

    state_t            state_reg, state_next;
    tgt_t              tgt_reg, tgt_next;
    logic              done_reg, done_next;
    logic              flag_reg, flag_next;
    logic [W-1:0]      n_reg, n_next;
    logic [W-1:0]      nm1_reg, nm1_next;
    logic [W-1:0]      sh_reg, sh_next;
    logic [1:0]        rem_reg, rem_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [W-1:0]      d_reg, d_next;
    logic [CW-1:0]     r_reg, r_next;
    logic [CW-1:0]     k_reg, k_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [W-1:0]      acc_reg, acc_next;
    logic [W-1:0]      sq_reg, sq_next;
    logic [W-1:0]      e_reg, e_next;
    logic [W-1:0]      mx_reg, mx_next;
    logic [W-1:0]      my_reg, my_next;
    logic [W-1:0]      mp_reg, mp_next;
    logic              phase_reg, phase_next;

    logic [W:0]        dbl;
    logic [W:0]        sum;
    logic [W-1:0]      dbl_red;
    logic [W-1:0]      sum_red;
    logic [W-1:0]      base_w;
    logic [1:0]        rem_step;

    // Shift-add modular multiplier datapath: double, then add one term
    always_comb
    begin
        dbl     = {mp_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, n_reg}) ? W'(dbl - {1'b0, n_reg}) : dbl[W-1:0];
        sum     = {1'b0, mp_reg} + (my_reg[W-1] ? {1'b0, mx_reg} : {(W+1){1'b0}});
        sum_red = (sum >= {1'b0, n_reg}) ? W'(sum - {1'b0, n_reg}) : sum[W-1:0];
    end

    assign base_w   = W'(witness_base(idx_reg));
    assign rem_step = mod3_step(rem_reg, sh_reg[W-1]);

    // Sequence the test
    always_comb
    begin
        state_next = state_reg;
        tgt_next   = tgt_reg;
        done_next  = 1'b0;
        flag_next  = flag_reg;
        n_next     = n_reg;
        nm1_next   = nm1_reg;
        sh_next    = sh_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        d_next     = d_reg;
        r_next     = r_reg;
        k_next     = k_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        sq_next    = sq_reg;
        e_next     = e_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        mp_next    = mp_reg;
        phase_next = phase_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    n_next     = candidate[W-1:0];
                    state_next = ST_CLASSIFY;
                end
            end

            // Decide the small cases directly
            ST_CLASSIFY:
            begin
                if (n_reg < W'(2))
                begin
                    flag_next  = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (n_reg == W'(2))
                begin
                    flag_next  = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (!n_reg[0])
                begin
                    flag_next  = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (n_reg < W'(SMALL_PRIME_LIMIT))
                begin
                    flag_next  = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    sh_next    = n_reg;
                    rem_next   = 2'd0;
                    cnt_next   = CNT_MAX;
                    state_next = ST_MOD3;
                end
            end

            // Reduce modulo 3 one bit per cycle
            ST_MOD3:
            begin
                rem_next = rem_step;
                sh_next  = {sh_reg[W-2:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    if (rem_step == 2'd0)
                    begin
                        flag_next  = 1'b0;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        d_next     = {n_reg[W-1:1], 1'b0};
                        nm1_next   = {n_reg[W-1:1], 1'b0};
                        r_next     = '0;
                        state_next = ST_SPLIT;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end

            // Strip factors of two from n-1
            ST_SPLIT:
            begin
                if (!d_reg[0])
                begin
                    d_next = {1'b0, d_reg[W-1:1]};
                    r_next = r_reg + CW'(1);
                end
                else
                begin
                    idx_next   = '0;
                    state_next = ST_BASE;
                end
            end

            // Pick the next base, skipping any not below n
            ST_BASE:
            begin
                if (base_w >= n_reg)
                begin
                    if (idx_reg == IDX_LAST)
                    begin
                        flag_next  = 1'b1;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    acc_next   = W'(1);
                    sq_next    = base_w;
                    e_next     = d_reg;
                    state_next = ST_EXP;
                end
            end

            // Square-and-multiply over the exponent bits, LSB first
            ST_EXP:
            begin
                if (e_reg == '0)
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    mx_next    = e_reg[0] ? acc_reg : sq_reg;
                    my_next    = sq_reg;
                    mp_next    = '0;
                    cnt_next   = CNT_MAX;
                    phase_next = 1'b0;
                    tgt_next   = e_reg[0] ? TGT_ACC_EXP : TGT_SQ;
                    state_next = ST_MUL;
                end
            end

            // Each multiplier bit takes two steps: double, then add
            ST_MUL:
            begin
                if (!phase_reg)
                begin
                    mp_next    = dbl_red;
                    phase_next = 1'b1;
                end
                else
                begin
                    mp_next    = sum_red;
                    my_next    = {my_reg[W-2:0], 1'b0};
                    phase_next = 1'b0;
                    if (cnt_reg == '0)
                    begin
                        case (tgt_reg)
                            TGT_ACC_EXP:
                            begin
                                acc_next   = sum_red;
                                mx_next    = sq_reg;
                                my_next    = sq_reg;
                                mp_next    = '0;
                                cnt_next   = CNT_MAX;
                                tgt_next   = TGT_SQ;
                            end
                            TGT_SQ:
                            begin
                                sq_next    = sum_red;
                                e_next     = {1'b0, e_reg[W-1:1]};
                                state_next = ST_EXP;
                            end
                            TGT_ACC_LOOP:
                            begin
                                acc_next   = sum_red;
                                state_next = ST_LOOP_CHK;
                            end
                            default:
                            begin
                                state_next = ST_IDLE;
                            end
                        endcase
                    end
                    else
                    begin
                        cnt_next = cnt_reg - CW'(1);
                    end
                end
            end

            // Pass the base on 1 or n-1, else start repeated squaring
            ST_CHECK:
            begin
                if (acc_reg == W'(1) || acc_reg == nm1_reg)
                begin
                    if (idx_reg == IDX_LAST)
                    begin
                        flag_next  = 1'b1;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_BASE;
                    end
                end
                else
                begin
                    k_next     = CW'(1);
                    state_next = ST_LOOP;
                end
            end

            ST_LOOP:
            begin
                if (k_reg >= r_reg)
                begin
                    flag_next  = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    mx_next    = acc_reg;
                    my_next    = acc_reg;
                    mp_next    = '0;
                    cnt_next   = CNT_MAX;
                    phase_next = 1'b0;
                    tgt_next   = TGT_ACC_LOOP;
                    state_next = ST_MUL;
                end
            end

            ST_LOOP_CHK:
            begin
                if (acc_reg == nm1_reg)
                begin
                    if (idx_reg == IDX_LAST)
                    begin
                        flag_next  = 1'b1;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_BASE;
                    end
                end
                else
                begin
                    k_next     = k_reg + CW'(1);
                    state_next = ST_LOOP;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, datapath and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            flag_reg  <= 1'b0;
            tgt_reg   <= TGT_ACC_EXP;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            flag_reg  <= flag_next;
            tgt_reg   <= tgt_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        nm1_reg  <= nm1_next;
        sh_reg   <= sh_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        d_reg    <= d_next;
        r_reg    <= r_next;
        k_reg    <= k_next;
        idx_reg  <= idx_next;
        acc_reg  <= acc_next;
        sq_reg   <= sq_next;
        e_reg    <= e_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        mp_reg   <= mp_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign prime_flag = flag_reg;

endmodule

`default_nettype wire

### sv/mrpt_checker.sv
`default_nettype none

module mrpt_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire logic prime_flag
);

    // An accepted request makes the unit busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but unit not busy");

    // A result appears only once the unit is idle again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // Every finished request ends in exactly one result
    a_done_on_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("request finished without a result");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // The flag is never unknown when it is delivered
    a_flag_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (prime_flag == 1'b0 || prime_flag == 1'b1))
        else $error("result flag unknown");

endmodule

bind miller_rabin_prime_test_32_unit mrpt_checker u_mrpt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .prime_flag (prime_flag)
);

`default_nettype wire

### bench/tb_top.sv
`default_nettype none

module tb_top;

    import mrpt_pkg::*;

    localparam logic FLAG_PRIME = 1'b1;
    localparam logic NOT_PRIME  = 1'b0;
    localparam logic FROM_TABLE = 1'b1;
    localparam logic FROM_MODEL = 1'b0;

    localparam int TESTED_W      = NUM_WIDTH_DEF;
    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_ITEMS  = 1000;
    // Longest run without progress before the watchdog stops the test
    localparam int STALL_LIMIT   = 60000;
    localparam int TAIL_CYCLES   = 50;

    typedef struct packed {
        logic [CAND_WIDTH-1:0] cand;
        logic                  typed;
        logic                  flag;
    } probe_row_t;

    typedef struct packed {
        logic [CAND_WIDTH-1:0] cand;
        logic                  flag;
    } verdict_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic [CAND_WIDTH-1:0] candidate = '0;
    logic                  busy;
    logic                  done;
    logic                  prime_flag;

    verdict_t pending_verdicts[$];
    int       mismatch_count = 0;
    int       burst_left     = 0;

    // Extremes, small cases, witness skipping and strong pseudoprimes
    probe_row_t directed_rows [DIRECTED_ROWS] = '{
        '{32'd0,          FROM_TABLE, NOT_PRIME},
        '{32'd1,          FROM_TABLE, NOT_PRIME},
        '{32'd2,          FROM_TABLE, FLAG_PRIME},
        '{32'd3,          FROM_TABLE, FLAG_PRIME},
        '{32'd4,          FROM_TABLE, NOT_PRIME},
        '{32'd5,          FROM_TABLE, FLAG_PRIME},
        '{32'd7,          FROM_TABLE, FLAG_PRIME},
        '{32'd8,          FROM_TABLE, NOT_PRIME},
        '{32'd9,          FROM_TABLE, NOT_PRIME},
        '{32'd15,         FROM_TABLE, NOT_PRIME},
        '{32'd63,         FROM_TABLE, NOT_PRIME},
        '{32'hFFFFFFFF,   FROM_TABLE, NOT_PRIME},
        '{32'hFFFFFFFE,   FROM_TABLE, NOT_PRIME},
        '{32'h80000000,   FROM_TABLE, NOT_PRIME},
        '{32'd11,         FROM_MODEL, FLAG_PRIME},
        '{32'd61,         FROM_MODEL, FLAG_PRIME},
        '{32'd67,         FROM_MODEL, FLAG_PRIME},
        '{32'd25,         FROM_MODEL, NOT_PRIME},
        '{32'd2047,       FROM_MODEL, NOT_PRIME},
        '{32'd1373653,    FROM_MODEL, NOT_PRIME},
        '{32'd25326001,   FROM_MODEL, NOT_PRIME},
        '{32'd3215031751, FROM_MODEL, NOT_PRIME},
        '{32'd65537,      FROM_MODEL, FLAG_PRIME},
        '{32'd2147483647, FROM_MODEL, FLAG_PRIME},
        '{32'd4294967291, FROM_MODEL, FLAG_PRIME}
    };

    miller_rabin_prime_test_32_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .candidate  (candidate),
        .done       (done),
        .prime_flag (prime_flag)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] mul_mod(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] m);
        return (a * b) % m;
    endfunction

    // Decide primality: small cases and divisibility by 3 first, then strong probes on bases 2, 7, 61
    function automatic logic expected_primality(input logic [CAND_WIDTH-1:0] raw);
        logic [31:0] n;
        logic [31:0] d;
        logic [31:0] e;
        logic [31:0] bases [3];
        logic [63:0] m;
        logic [63:0] nm1;
        logic [63:0] acc;
        logic [63:0] sq;
        logic        passed;
        int          r;
        int          i;
        int          k;
        n = 32'(64'(raw) & ((64'd1 << TESTED_W) - 64'd1));
        bases[0] = 32'd2;
        bases[1] = 32'd7;
        bases[2] = 32'd61;
        if (n < 32'd2)
            return NOT_PRIME;
        if (n == 32'd2)
            return FLAG_PRIME;
        if (!n[0])
            return NOT_PRIME;
        if (n < 32'd9)
            return FLAG_PRIME;
        if (n % 32'd3 == 32'd0)
            return NOT_PRIME;
        d = n - 32'd1;
        r = 0;
        while (!d[0])
        begin
            d = d >> 1;
            r++;
        end
        m   = 64'(n);
        nm1 = m - 64'd1;
        for (i = 0; i < 3; i++)
        begin
            if (bases[i] >= n)
                continue;
            acc = 64'd1;
            sq  = 64'(bases[i]) % m;
            e   = d;
            while (e != 32'd0)
            begin
                if (e[0])
                    acc = mul_mod(acc, sq, m);
                sq = mul_mod(sq, sq, m);
                e  = e >> 1;
            end
            passed = (acc == 64'd1) || (acc == nm1);
            for (k = 1; k < r && !passed; k++)
            begin
                acc = mul_mod(acc, acc, m);
                if (acc == nm1)
                    passed = 1'b1;
            end
            if (!passed)
                return NOT_PRIME;
        end
        return FLAG_PRIME;
    endfunction

    // Draw odd values until one is prime; give up after a bounded search
    function automatic logic [CAND_WIDTH-1:0] draw_prime();
        logic [CAND_WIDTH-1:0] n;
        n = $urandom | 32'd1;
        for (int tries = 0; tries < 300; tries++)
        begin
            if (expected_primality(n) == FLAG_PRIME)
                return n;
            n = $urandom | 32'd1;
        end
        return n;
    endfunction

    function automatic logic [CAND_WIDTH-1:0] draw_candidate();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            return CAND_WIDTH'($urandom_range(0, 255));
        else if (pick < 50)
            return CAND_WIDTH'($urandom_range(0, 65535));
        else if (pick < 65)
            return ($urandom_range(0, 1) == 0) ? ($urandom & ~32'd1)
                                               : 32'd3 * $urandom_range(1, 1431655765);
        else if (pick < 90)
            return $urandom;
        else
            return draw_prime();
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Hold the request until busy reads low, then record its verdict
    task automatic issue_request(input logic [CAND_WIDTH-1:0] n, input logic typed,
                                 input logic flag);
        verdict_t v;
        candidate <= n;
        start     <= 1'b1;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        v.cand = n;
        v.flag = typed ? flag : expected_primality(n);
        pending_verdicts.push_back(v);
    endtask

    // Keep start high inside a burst; otherwise drop it for a random gap
    task automatic pace_sender();
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        start <= 1'b0;
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                 : $urandom_range(0, 4);
        if ($urandom_range(0, 1) == 0)
        begin
            repeat ($urandom_range(1, 20))
                @(posedge clk);
        end
        else
        begin
            @(posedge clk);
            while (busy !== 1'b0)
                @(posedge clk);
            repeat ($urandom_range(0, 4))
                @(posedge clk);
        end
    endtask

    // Drop start and wait until every outstanding request has answered
    task automatic drain_requests();
        start <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // Compare each answer with the oldest outstanding verdict
    always @(posedge clk)
    begin : check_results
        verdict_t head;
        if (rst_n && done === 1'b1)
        begin
            if (pending_verdicts.size() == 0)
                report_mismatch("result with no request outstanding");
            else
            begin
                head = pending_verdicts.pop_front();
                if (prime_flag !== head.flag)
                    report_mismatch($sformatf("candidate %0d: prime_flag %b, want %b",
                                              head.cand, prime_flag, head.flag));
            end
        end
    end

    // Stop the run when neither side has moved for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && busy === 1'b0) || done === 1'b1)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : stimulus
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        repeat (2)
            @(posedge clk);

        // Walk the directed table
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            issue_request(directed_rows[i].cand, directed_rows[i].typed,
                          directed_rows[i].flag);
            pace_sender();
        end
        drain_requests();

        // Random candidates, with a full drain halfway through
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            issue_request(draw_candidate(), FROM_MODEL, NOT_PRIME);
            if (i == RANDOM_ITEMS / 2)
                drain_requests();
            else
                pace_sender();
        end
        drain_requests();
        repeat (TAIL_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0 && pending_verdicts.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
